// File: sv/polygon_fan_vertex_assembler_defines.svh
// assertion macros for the polygon fan vertex assembler
// used by pfva_back, no other dependencies
// define NO_ASSERTIONS to compile the checks out
`ifndef POLYGON_FAN_VERTEX_ASSEMBLER_DEFINES_SVH
`define POLYGON_FAN_VERTEX_ASSEMBLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold on every edge out of reset
`define PFVA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pfva assertion failed");
// condition must never be true out of reset
`define PFVA_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pfva forbidden condition seen");
`else
`define PFVA_ASSERT(lbl, clk, rst_n, prop)
`define PFVA_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: sv/pfva_pkg.sv
// shared types, constants and the fan corner order
// no dependencies
`timescale 1ns / 1ps

package pfva_pkg;

  // default table depth and queue depths (queue depths are powers of two)
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int CMD_DEPTH_DEF   = 2;
  localparam int OUT_DEPTH_DEF   = 4;

  // fixed field widths
  localparam int WORD_W   = 32;
  localparam int ENTRY_W  = 10;
  localparam int CORNER_W = 11;
  localparam int COUNT_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] DEFAULT_X_RESET = 32'h0000_0000;
  localparam logic [WORD_W-1:0] DEFAULT_Y_RESET = 32'h0000_0000;
  localparam logic [WORD_W-1:0] DEFAULT_Z_RESET = 32'h3F80_0000;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FACE  = 1'b1;

  // smallest corner count that makes a triangle, and a quad
  localparam logic [COUNT_W-1:0] COUNT_TRI  = 3'd3;
  localparam logic [COUNT_W-1:0] COUNT_QUAD = 3'd4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEFAULT_X = 2'd0,
    REG_DEFAULT_Y = 2'd1,
    REG_DEFAULT_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } vertex_t;

  // classified face handed from front to back
  typedef struct packed {
    logic                    quad;
    logic [3:0]              use_def;
    logic [3:0][ENTRY_W-1:0] idx;
  } face_cmd_t;

  // one emitted vertex
  typedef struct packed {
    vertex_t v;
    logic    tri_num;
    logic    used_def;
    logic    last;
  } out_item_t;

  // back status seen by the front
  typedef struct packed {
    logic rd_busy;
    logic cmd_loading;
  } back_stat_t;

  // fan step to corner: 0 1 2 for the first triangle, 0 2 3 for the second
  function automatic logic [1:0] corner_sel(input logic [2:0] step);
    logic [1:0] sel;
    case (step)
      3'd0:    sel = 2'd0;
      3'd1:    sel = 2'd1;
      3'd2:    sel = 2'd2;
      3'd3:    sel = 2'd0;
      3'd4:    sel = 2'd2;
      3'd5:    sel = 2'd3;
      default: sel = 2'd0;
    endcase
    return sel;
  endfunction

endpackage

// File: sv/pfva_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module pfva_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/pfva_fifo.sv
// small register queue, power of two depth, head shown combinationally
// no dependencies
`timescale 1ns / 1ps

module pfva_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [WIDTH-1:0]         push_data,
  input  logic                     pop,
  output logic [WIDTH-1:0]         pop_data,
  output logic                     full,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int PW = $clog2(DEPTH);
  localparam logic [PW:0] DEPTH_C = (PW + 1)'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full  = (count_r == DEPTH_C);
  assign empty = (count_r == '0);
  assign count = count_r;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/pfva_front.sv
// front end: input register, table writes and face classification
// depends on pfva_pkg
`timescale 1ns / 1ps

module pfva_front #(
  parameter int TABLE_DEPTH = pfva_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_kind,
  input  logic [pfva_pkg::ENTRY_W-1:0]        in_entry_index,
  input  logic [pfva_pkg::WORD_W-1:0]         in_x,
  input  logic [pfva_pkg::WORD_W-1:0]         in_y,
  input  logic [pfva_pkg::WORD_W-1:0]         in_z,
  input  logic [pfva_pkg::COUNT_W-1:0]        in_corner_count,
  input  logic signed [pfva_pkg::CORNER_W-1:0] in_corner_a,
  input  logic signed [pfva_pkg::CORNER_W-1:0] in_corner_b,
  input  logic signed [pfva_pkg::CORNER_W-1:0] in_corner_c,
  input  logic signed [pfva_pkg::CORNER_W-1:0] in_corner_d,
  // table write port
  output logic                                tbl_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]      tbl_waddr,
  output pfva_pkg::vertex_t                   tbl_wdata,
  // face command queue
  output logic                                cmd_push,
  output pfva_pkg::face_cmd_t                 cmd_data,
  input  logic                                cmd_full,
  input  logic                                cmd_empty,
  input  pfva_pkg::back_stat_t                bstat
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int DW = 18;
  localparam logic [DW-1:0] DEPTH_C = DW'(TABLE_DEPTH);

  logic                                hold_valid_r, hold_valid_nxt;
  logic                                kind_r;
  logic [pfva_pkg::ENTRY_W-1:0]        entry_r;
  pfva_pkg::vertex_t                   vtx_r;
  logic [pfva_pkg::COUNT_W-1:0]        count_r;
  logic [3:0][pfva_pkg::CORNER_W-1:0]  corner_r;
  logic                                nonempty_r, nonempty_nxt;

  logic is_write, is_short, drain, accept, entry_ok;

  // classify the held item
  assign is_write = (kind_r == pfva_pkg::KIND_WRITE);
  assign is_short = (count_r < pfva_pkg::COUNT_TRI);
  assign entry_ok = (DW'(entry_r) < DEPTH_C);

  // a write waits until no earlier face can still read the table
  assign drain = hold_valid_r &&
                 (is_write ? (cmd_empty && !bstat.rd_busy && !bstat.cmd_loading)
                           : (is_short || !cmd_full));
  assign in_full = hold_valid_r && !drain;
  assign accept  = in_push && !in_full;

  // table write
  assign tbl_we    = drain && is_write && entry_ok;
  assign tbl_waddr = AW'(entry_r);
  assign tbl_wdata = vtx_r;

  // face command, corners resolved against the table state at this point
  always_comb begin
    cmd_data.quad = (count_r >= pfva_pkg::COUNT_QUAD);
    for (int i = 0; i < 4; i++) begin
      cmd_data.idx[i]     = corner_r[i][pfva_pkg::ENTRY_W-1:0];
      cmd_data.use_def[i] = !nonempty_r || corner_r[i][pfva_pkg::CORNER_W-1] ||
                            !(DW'(corner_r[i][pfva_pkg::ENTRY_W-1:0]) < DEPTH_C);
    end
  end
  assign cmd_push = drain && !is_write && !is_short;

  // holding register control
  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (drain) begin
      hold_valid_nxt = 1'b0;
    end
    nonempty_nxt = nonempty_r || tbl_we;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      nonempty_r   <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      nonempty_r   <= nonempty_nxt;
    end
  end

  // held payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= in_kind;
      entry_r     <= in_entry_index;
      vtx_r.x     <= in_x;
      vtx_r.y     <= in_y;
      vtx_r.z     <= in_z;
      count_r     <= in_corner_count;
      corner_r[0] <= in_corner_a;
      corner_r[1] <= in_corner_b;
      corner_r[2] <= in_corner_c;
      corner_r[3] <= in_corner_d;
    end
  end

endmodule

// File: sv/pfva_back.sv
// back end: fan sequencer, table reads and result queue
// depends on pfva_pkg, pfva_fifo and the assertion macro header
`timescale 1ns / 1ps
`include "polygon_fan_vertex_assembler_defines.svh"

module pfva_back #(
  parameter int TABLE_DEPTH = pfva_pkg::TABLE_DEPTH_DEF,
  parameter int OUT_DEPTH   = pfva_pkg::OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // face command queue
  input  pfva_pkg::face_cmd_t            cmd_data,
  input  logic                           cmd_empty,
  output logic                           cmd_pop,
  output pfva_pkg::back_stat_t           bstat,
  // table read port
  output logic                           tbl_re,
  output logic [$clog2(TABLE_DEPTH)-1:0] tbl_raddr,
  input  pfva_pkg::vertex_t              tbl_rdata,
  // default vertex
  input  pfva_pkg::vertex_t              dflt,
  // result channel
  output logic                           out_empty,
  input  logic                           out_pop,
  output pfva_pkg::out_item_t            out_item
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH) + 1;
  localparam logic [CW:0] OUT_DEPTH_C = (CW + 1)'(OUT_DEPTH);

  logic                 busy_r, busy_nxt;
  pfva_pkg::face_cmd_t  cmd_r;
  logic [2:0]           step_r, step_nxt;
  logic                 s1_valid_r, s1_def_r, s1_tri_r, s1_last_r;

  logic [1:0]           sel;
  logic                 last_step, issue, load, credit;
  logic [CW-1:0]        out_count;
  logic                 out_full;
  pfva_pkg::out_item_t  push_item;

  // read issue with room reserved for the read in flight
  assign credit    = ((CW + 1)'(out_count) + (CW + 1)'(s1_valid_r)) < OUT_DEPTH_C;
  assign sel       = pfva_pkg::corner_sel(step_r);
  assign last_step = cmd_r.quad ? (step_r == 3'd5) : (step_r == 3'd2);
  assign issue     = busy_r && credit;
  assign load      = !cmd_empty && (!busy_r || (issue && last_step));
  assign cmd_pop   = load;

  assign tbl_re    = issue;
  assign tbl_raddr = AW'(cmd_r.idx[sel]);

  assign bstat.rd_busy     = busy_r;
  assign bstat.cmd_loading = load;

  // sequencer
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (load) begin
      busy_nxt = 1'b1;
      step_nxt = 3'd0;
    end else if (issue) begin
      busy_nxt = !last_step;
      step_nxt = step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      step_r     <= 3'd0;
      s1_valid_r <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      step_r     <= step_nxt;
      s1_valid_r <= issue;
    end
  end

  // current face and read stage tags
  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= cmd_data;
    end
    if (issue) begin
      s1_def_r  <= cmd_r.use_def[sel];
      s1_tri_r  <= (step_r >= 3'd3);
      s1_last_r <= last_step;
    end
  end

  // pick table data or default vertex
  always_comb begin
    push_item.v        = s1_def_r ? dflt : tbl_rdata;
    push_item.tri_num  = s1_tri_r;
    push_item.used_def = s1_def_r;
    push_item.last     = s1_last_r;
  end

  // result queue
  pfva_fifo #(
    .WIDTH ($bits(pfva_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (push_item),
    .pop       (out_pop),
    .pop_data  (out_item),
    .full      (out_full),
    .empty     (out_empty),
    .count     (out_count)
  );

  // checks
  `PFVA_NEVER(a_out_no_overflow, clk, rst_n, s1_valid_r && out_full)
  `PFVA_ASSERT(a_read_from_busy, clk, rst_n, s1_valid_r |-> $past(busy_r))
  `PFVA_ASSERT(a_face_ends, clk, rst_n, (issue && last_step && !load) |=> !busy_r)
  `PFVA_ASSERT(a_tri_step_bound, clk, rst_n, (busy_r && !cmd_r.quad) |-> (step_r <= 3'd2))

endmodule

// File: sv/polygon_fan_vertex_assembler.sv
// Triangle fan vertex assembler with an xyz vertex table.
// A face passes the input register, the command queue, the sequencer and the table read register into the result queue.
// Throughput: one vertex per cycle from the single table read port while the result queue has room: six per quad face,
// three per triangle; a table write waits until earlier faces have finished reading the table.
// Reset: synchronous, clears control state and loads the default vertex reset values, no clearing pass over the table.
// top level: configuration registers, front, command queue, table ram, back
// depends on pfva_pkg, pfva_front, pfva_fifo, pfva_ram, pfva_back
`timescale 1ns / 1ps

module polygon_fan_vertex_assembler #(
  parameter int TABLE_DEPTH = pfva_pkg::TABLE_DEPTH_DEF,
  parameter int CMD_DEPTH   = pfva_pkg::CMD_DEPTH_DEF,
  parameter int OUT_DEPTH   = pfva_pkg::OUT_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [pfva_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfva_pkg::WORD_W-1:0]          cfg_data,
  // input channel
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_kind,
  input  logic [pfva_pkg::ENTRY_W-1:0]         in_entry_index,
  input  logic [pfva_pkg::WORD_W-1:0]          in_x,
  input  logic [pfva_pkg::WORD_W-1:0]          in_y,
  input  logic [pfva_pkg::WORD_W-1:0]          in_z,
  input  logic [pfva_pkg::COUNT_W-1:0]         in_corner_count,
  input  logic signed [pfva_pkg::CORNER_W-1:0] in_corner_a,
  input  logic signed [pfva_pkg::CORNER_W-1:0] in_corner_b,
  input  logic signed [pfva_pkg::CORNER_W-1:0] in_corner_c,
  input  logic signed [pfva_pkg::CORNER_W-1:0] in_corner_d,
  // result channel
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [pfva_pkg::WORD_W-1:0]          out_x,
  output logic [pfva_pkg::WORD_W-1:0]          out_y,
  output logic [pfva_pkg::WORD_W-1:0]          out_z,
  output logic                                 out_triangle_number,
  output logic                                 out_used_default,
  output logic                                 out_last
);

  localparam int AW = $clog2(TABLE_DEPTH);

  pfva_pkg::vertex_t    dflt_r, dflt_nxt;
  logic                 tbl_we, tbl_re;
  logic [AW-1:0]        tbl_waddr, tbl_raddr;
  pfva_pkg::vertex_t    tbl_wdata, tbl_rdata;
  logic                 cmd_push, cmd_pop, cmd_full, cmd_empty;
  pfva_pkg::face_cmd_t  cmd_in, cmd_out;
  pfva_pkg::back_stat_t bstat;
  pfva_pkg::out_item_t  out_item;

  // default vertex registers
  always_comb begin
    dflt_nxt = dflt_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pfva_pkg::REG_DEFAULT_X: dflt_nxt.x = cfg_data;
        pfva_pkg::REG_DEFAULT_Y: dflt_nxt.y = cfg_data;
        pfva_pkg::REG_DEFAULT_Z: dflt_nxt.z = cfg_data;
        default:                 dflt_nxt = dflt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r.x <= pfva_pkg::DEFAULT_X_RESET;
      dflt_r.y <= pfva_pkg::DEFAULT_Y_RESET;
      dflt_r.z <= pfva_pkg::DEFAULT_Z_RESET;
    end else begin
      dflt_r <= dflt_nxt;
    end
  end

  // front end
  pfva_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_kind         (in_kind),
    .in_entry_index  (in_entry_index),
    .in_x            (in_x),
    .in_y            (in_y),
    .in_z            (in_z),
    .in_corner_count (in_corner_count),
    .in_corner_a     (in_corner_a),
    .in_corner_b     (in_corner_b),
    .in_corner_c     (in_corner_c),
    .in_corner_d     (in_corner_d),
    .tbl_we          (tbl_we),
    .tbl_waddr       (tbl_waddr),
    .tbl_wdata       (tbl_wdata),
    .cmd_push        (cmd_push),
    .cmd_data        (cmd_in),
    .cmd_full        (cmd_full),
    .cmd_empty       (cmd_empty),
    .bstat           (bstat)
  );

  // face command queue between front and back
  pfva_fifo #(
    .WIDTH ($bits(pfva_pkg::face_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .full      (cmd_full),
    .empty     (cmd_empty),
    .count     ()
  );

  // vertex table
  pfva_ram #(
    .WIDTH ($bits(pfva_pkg::vertex_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // back end
  pfva_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .OUT_DEPTH   (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_data  (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .bstat     (bstat),
    .tbl_re    (tbl_re),
    .tbl_raddr (tbl_raddr),
    .tbl_rdata (tbl_rdata),
    .dflt      (dflt_r),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // result fields
  assign out_x               = out_item.v.x;
  assign out_y               = out_item.v.y;
  assign out_z               = out_item.v.z;
  assign out_triangle_number = out_item.tri_num;
  assign out_used_default    = out_item.used_def;
  assign out_last            = out_item.last;

endmodule
